### rtl/poisson_stencil_row_generator_core_defines.svh
// Assertion macros shared by the row generator RTL.
// Included by the modules that check their own logic; needs no other file.
`ifndef POISSON_STENCIL_ROW_GENERATOR_CORE_DEFINES_SVH
`define POISSON_STENCIL_ROW_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTH

// The condition holds at every clock edge outside reset.
`define PSRG_ASSERT_ALW(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("psrg: assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define PSRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psrg: assertion failed");

// The consequent holds in the cycle after the antecedent.
`define PSRG_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psrg: assertion failed");

`else

`define PSRG_ASSERT_ALW(lbl, clk, rst_n, cond)
`define PSRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PSRG_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### rtl/psrg_pkg.sv
// Shared constants, codes and structures of the stencil row generator.
// Used by every module of the block; depends on nothing else.
package psrg_pkg;

  localparam int MAX_CELLS = 256;

  localparam int ROW_W   = 24;
  localparam int SIZE_W  = 9;
  localparam int COEF_W  = 32;
  localparam int OUT_W   = 36;
  localparam int DATA_W  = 32;
  localparam int CFG_IDX_W = 3;

  // Coordinate, grid size, plane and volume widths follow from the largest grid.
  localparam int CRD_W  = $clog2(MAX_CELLS);
  localparam int NRM_W  = CRD_W + 1;
  localparam int PLN_W  = 2 * CRD_W + 1;
  localparam int TOT_W  = 3 * CRD_W + 1;
  localparam int DIV_W  = (ROW_W > PLN_W + CRD_W - 1) ? ROW_W : PLN_W + CRD_W - 1;
  localparam int NDIV   = 2 * CRD_W;
  localparam int TERM_W = COEF_W + 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int NPOS = 7;
  localparam int NAX  = 3;
  localparam int AX_X = 0;
  localparam int AX_Y = 1;
  localparam int AX_Z = 2;

  localparam logic [OUT_W-1:0]  ONE_Q16  = OUT_W'(65536);
  localparam logic [SIZE_W-1:0] RST_SIZE = SIZE_W'(8);
  localparam logic [COEF_W-1:0] RST_COEF = COEF_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BOUNDARY_MODE = 3'd0,
    REG_SIZE_X        = 3'd1,
    REG_SIZE_Y        = 3'd2,
    REG_SIZE_Z        = 3'd3,
    REG_COEF_X        = 3'd4,
    REG_COEF_Y        = 3'd5,
    REG_COEF_Z        = 3'd6
  } cfg_reg_t;

  // Entry positions of a row, in emission order.
  typedef enum logic [2:0] {
    POS_ZM   = 3'd0,
    POS_YM   = 3'd1,
    POS_XM   = 3'd2,
    POS_DIAG = 3'd3,
    POS_ZP   = 3'd4,
    POS_YP   = 3'd5,
    POS_XP   = 3'd6
  } pos_t;

  localparam logic [NPOS-1:0] MASK_DIAG = NPOS'(1) << POS_DIAG;
  localparam logic [NPOS-1:0] MASK_ALL  = {NPOS{1'b1}};

  // Grid geometry and coefficients derived from the configuration registers.
  typedef struct packed {
    logic              periodic;
    logic [NRM_W-1:0]  nx;
    logic [NRM_W-1:0]  ny;
    logic [NRM_W-1:0]  nz;
    logic [PLN_W-1:0]  plane;
    logic [TOT_W-1:0]  total;
    logic [ROW_W-1:0]  off_zw;
    logic [ROW_W-1:0]  off_yw;
    logic [ROW_W-1:0]  off_xw;
    logic [COEF_W-1:0] cx;
    logic [COEF_W-1:0] cy;
    logic [COEF_W-1:0] cz;
    logic [OUT_W-1:0]  diag_per;
  } geom_t;

  // One stage of the coordinate division pipeline.
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic [DIV_W-1:0] rem;
    logic [CRD_W-1:0] qz;
    logic [CRD_W-1:0] qy;
  } div_t;

  // A classified row before its diagonal is summed.
  typedef struct packed {
    logic              valid;
    logic              err;
    logic              pinned;
    logic [ROW_W-1:0]  row;
    logic [NPOS-1:0]   mask;
    logic [NAX-1:0]    lo;
    logic [NAX-1:0]    hi;
    logic [TERM_W-1:0] tx;
    logic [TERM_W-1:0] ty;
    logic [TERM_W-1:0] tz;
  } cls_t;

  // A row ready for emission, as held in the queue.
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [NPOS-1:0]  mask;
    logic [NAX-1:0]   lo;
    logic [NAX-1:0]   hi;
    logic [OUT_W-1:0] diag;
    logic             err;
  } qent_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

### rtl/poisson_stencil_row_generator_core.sv
// Top level of the seven-point Poisson matrix row generator: configuration
// registers, derived grid geometry, and the front end, queue and emitter.
// Depends on psrg_pkg, psrg_front, psrg_fifo and psrg_back.
//
//   Channel  Direction  Handshake           Payload
//   in       input      in_valid/in_stall   in_row_index
//   out      output     out_valid/out_stall out_column_index, out_coefficient,
//                                           out_row_error, out_last_entry
//   cfg      input      cfg_we              cfg_index, cfg_data
//
// Each input transaction produces one to seven output transactions, one per
// cycle while the output is not stalled; the emitter takes up the next row
// only after the last entry of the current one (seven entries for an interior
// row, fewer at a wall unless periodic, one for a pinned or out-of-range row).
// The front end takes a row every cycle unless the queue is full and a row
// waits to enter it. A row's first entry appears after the row passes the 16
// coordinate divider stages, classification, the queue and the output register.
// Reset is synchronous and active low; it restores the default configuration
// and empties the pipeline, the queue and the output register.
// A stall on the output holds the output register; the four-entry queue then
// fills and the front end stalls its input only when the queue is full.

module poisson_stencil_row_generator_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [psrg_pkg::ROW_W-1:0]            in_row_index,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [psrg_pkg::ROW_W-1:0]            out_column_index,
  output logic signed [psrg_pkg::OUT_W-1:0]     out_coefficient,
  output logic                                  out_row_error,
  output logic                                  out_last_entry,
  input  logic                                  cfg_we,
  input  logic [psrg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [psrg_pkg::DATA_W-1:0]           cfg_data
);

  // Configuration registers.
  logic                         mode_r;
  logic [psrg_pkg::SIZE_W-1:0]  size_x_r;
  logic [psrg_pkg::SIZE_W-1:0]  size_y_r;
  logic [psrg_pkg::SIZE_W-1:0]  size_z_r;
  logic [psrg_pkg::COEF_W-1:0]  coef_x_r;
  logic [psrg_pkg::COEF_W-1:0]  coef_y_r;
  logic [psrg_pkg::COEF_W-1:0]  coef_z_r;

  // Derived geometry, recomputed every cycle from the registers above.
  logic [psrg_pkg::NRM_W-1:0]   nx;
  logic [psrg_pkg::NRM_W-1:0]   ny;
  logic [psrg_pkg::NRM_W-1:0]   nz;
  logic [psrg_pkg::PLN_W-1:0]   plane_r;
  logic [psrg_pkg::TOT_W-1:0]   total_r;
  logic [psrg_pkg::ROW_W-1:0]   off_zw_r;
  logic [psrg_pkg::ROW_W-1:0]   off_yw_r;
  logic [psrg_pkg::ROW_W-1:0]   off_xw_r;
  logic [psrg_pkg::COEF_W+1:0]  csum_r;
  logic [psrg_pkg::OUT_W-1:0]   diag_per_r;
  psrg_pkg::geom_t              geom;

  psrg_pkg::qent_t              push_data;
  psrg_pkg::qent_t              head;
  psrg_pkg::fifo_stat_t         q_stat;
  logic                         push;
  logic                         pop;

  // A size below three acts as three and one above the grid limit as the limit.
  function automatic logic [psrg_pkg::NRM_W-1:0] eff_size(
    input logic [psrg_pkg::SIZE_W-1:0] s
  );
    logic [psrg_pkg::NRM_W-1:0] r;
    if (int'(s) < 3) begin
      r = psrg_pkg::NRM_W'(3);
    end else if (int'(s) > psrg_pkg::MAX_CELLS) begin
      r = psrg_pkg::NRM_W'(psrg_pkg::MAX_CELLS);
    end else begin
      r = psrg_pkg::NRM_W'(s);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      size_x_r <= psrg_pkg::RST_SIZE;
      size_y_r <= psrg_pkg::RST_SIZE;
      size_z_r <= psrg_pkg::RST_SIZE;
      coef_x_r <= psrg_pkg::RST_COEF;
      coef_y_r <= psrg_pkg::RST_COEF;
      coef_z_r <= psrg_pkg::RST_COEF;
    end else if (cfg_we) begin
      case (cfg_index)
        psrg_pkg::REG_BOUNDARY_MODE: mode_r   <= cfg_data[0];
        psrg_pkg::REG_SIZE_X:        size_x_r <= cfg_data[psrg_pkg::SIZE_W-1:0];
        psrg_pkg::REG_SIZE_Y:        size_y_r <= cfg_data[psrg_pkg::SIZE_W-1:0];
        psrg_pkg::REG_SIZE_Z:        size_z_r <= cfg_data[psrg_pkg::SIZE_W-1:0];
        psrg_pkg::REG_COEF_X:        coef_x_r <= cfg_data[psrg_pkg::COEF_W-1:0];
        psrg_pkg::REG_COEF_Y:        coef_y_r <= cfg_data[psrg_pkg::COEF_W-1:0];
        psrg_pkg::REG_COEF_Z:        coef_z_r <= cfg_data[psrg_pkg::COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // In periodic mode the ghost layer on each side is not part of the grid.
  always_comb begin
    nx = eff_size(size_x_r);
    ny = eff_size(size_y_r);
    nz = eff_size(size_z_r);
    if (mode_r) begin
      nx = nx - psrg_pkg::NRM_W'(2);
      ny = ny - psrg_pkg::NRM_W'(2);
      nz = nz - psrg_pkg::NRM_W'(2);
    end
  end

  // After a register write the derived values settle through plane_r, total_r
  // and off_zw_r in turn; plane_r is needed in the cycle after a row is taken,
  // the rest much later. The two products are kept one register apart.
  always_ff @(posedge clk) begin
    plane_r    <= psrg_pkg::PLN_W'(psrg_pkg::PLN_W'(nx) * psrg_pkg::PLN_W'(ny));
    total_r    <= psrg_pkg::TOT_W'(psrg_pkg::TOT_W'(plane_r) * psrg_pkg::TOT_W'(nz));
    off_zw_r   <= psrg_pkg::ROW_W'(total_r - psrg_pkg::TOT_W'(plane_r));
    off_yw_r   <= psrg_pkg::ROW_W'(plane_r - psrg_pkg::PLN_W'(nx));
    off_xw_r   <= psrg_pkg::ROW_W'(nx - psrg_pkg::NRM_W'(1));
    csum_r     <= (psrg_pkg::COEF_W + 2)'(coef_x_r) + (psrg_pkg::COEF_W + 2)'(coef_y_r) +
                  (psrg_pkg::COEF_W + 2)'(coef_z_r);
    diag_per_r <= psrg_pkg::OUT_W'(0) - (psrg_pkg::OUT_W'(csum_r) << 1);
  end

  always_comb begin
    geom.periodic = mode_r;
    geom.nx       = nx;
    geom.ny       = ny;
    geom.nz       = nz;
    geom.plane    = plane_r;
    geom.total    = total_r;
    geom.off_zw   = off_zw_r;
    geom.off_yw   = off_yw_r;
    geom.off_xw   = off_xw_r;
    geom.cx       = coef_x_r;
    geom.cy       = coef_y_r;
    geom.cz       = coef_z_r;
    geom.diag_per = diag_per_r;
  end

  psrg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_valid),
    .in_row_i    (in_row_index),
    .in_stall_o  (in_stall),
    .geom_i      (geom),
    .full_i      (q_stat.full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  psrg_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (q_stat)
  );

  psrg_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .geom_i             (geom),
    .head_i             (head),
    .stat_i             (q_stat),
    .pop_o              (pop),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .out_column_index_o (out_column_index),
    .out_coefficient_o  (out_coefficient),
    .out_row_error_o    (out_row_error),
    .out_last_entry_o   (out_last_entry)
  );

endmodule

### rtl/psrg_front.sv
// Front end: accepts row indices, splits them into cell coordinates in a
// pipelined restoring divider, classifies the row. Depends on psrg_pkg.
`include "poisson_stencil_row_generator_core_defines.svh"

module psrg_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid_i,
  input  logic [psrg_pkg::ROW_W-1:0] in_row_i,
  output logic                    in_stall_o,
  input  psrg_pkg::geom_t         geom_i,
  input  logic                    full_i,
  output logic                    push_o,
  output psrg_pkg::qent_t         push_data_o
);

  psrg_pkg::div_t div_r   [0:psrg_pkg::NDIV];
  psrg_pkg::div_t div_nxt [0:psrg_pkg::NDIV];
  psrg_pkg::cls_t cls_r;
  psrg_pkg::cls_t cls_nxt;
  logic           adv;

  // The whole pipeline moves as one; it holds only when the classified row
  // at its end cannot enter the queue.
  assign adv        = !cls_r.valid || !full_i;
  assign in_stall_o = !adv;
  assign push_o     = cls_r.valid && !full_i;

  // One quotient bit per stage: z over the plane size, then y over nx.
  always_comb begin
    logic [psrg_pkg::DIV_W-1:0] dvs;
    logic                       ge;
    div_nxt[0].valid = in_valid_i;
    div_nxt[0].row   = in_row_i;
    div_nxt[0].rem   = psrg_pkg::DIV_W'(in_row_i);
    div_nxt[0].qz    = '0;
    div_nxt[0].qy    = '0;
    for (int k = 1; k <= psrg_pkg::NDIV; k++) begin
      div_nxt[k] = div_r[k-1];
      if (k <= psrg_pkg::CRD_W) begin
        dvs = psrg_pkg::DIV_W'(geom_i.plane) << (psrg_pkg::CRD_W - k);
      end else begin
        dvs = psrg_pkg::DIV_W'(geom_i.nx) << (psrg_pkg::NDIV - k);
      end
      ge = div_r[k-1].rem >= dvs;
      if (ge) begin
        div_nxt[k].rem = div_r[k-1].rem - dvs;
      end
      if (k <= psrg_pkg::CRD_W) begin
        div_nxt[k].qz = {div_r[k-1].qz[psrg_pkg::CRD_W-2:0], ge};
      end else begin
        div_nxt[k].qy = {div_r[k-1].qy[psrg_pkg::CRD_W-2:0], ge};
      end
    end
  end

  // Classification: range check, walls, pinned row, present entries, diagonal terms.
  always_comb begin
    psrg_pkg::div_t              s;
    logic [psrg_pkg::CRD_W-1:0]  cx;
    logic [psrg_pkg::CRD_W-1:0]  cy;
    logic [psrg_pkg::CRD_W-1:0]  cz;
    logic [psrg_pkg::NAX-1:0]    lo;
    logic [psrg_pkg::NAX-1:0]    hi;
    logic                        pin;
    logic                        err;
    logic [psrg_pkg::NPOS-1:0]   m;
    s   = div_r[psrg_pkg::NDIV];
    cx  = s.rem[psrg_pkg::CRD_W-1:0];
    cy  = s.qy;
    cz  = s.qz;
    err = psrg_pkg::TOT_W'(s.row) >= geom_i.total;
    lo[psrg_pkg::AX_X] = cx == '0;
    lo[psrg_pkg::AX_Y] = cy == '0;
    lo[psrg_pkg::AX_Z] = cz == '0;
    hi[psrg_pkg::AX_X] = psrg_pkg::NRM_W'(cx) == geom_i.nx - psrg_pkg::NRM_W'(1);
    hi[psrg_pkg::AX_Y] = psrg_pkg::NRM_W'(cy) == geom_i.ny - psrg_pkg::NRM_W'(1);
    hi[psrg_pkg::AX_Z] = psrg_pkg::NRM_W'(cz) == geom_i.nz - psrg_pkg::NRM_W'(1);
    if (geom_i.periodic) begin
      pin = (psrg_pkg::NRM_W'(cx) == (geom_i.nx >> 1)) &&
            (psrg_pkg::NRM_W'(cy) == (geom_i.ny >> 1)) &&
            (psrg_pkg::NRM_W'(cz) == (geom_i.nz >> 1));
      m   = psrg_pkg::MASK_ALL;
    end else begin
      pin = (cx == psrg_pkg::CRD_W'(1)) && (cy == psrg_pkg::CRD_W'(1)) &&
            (cz == psrg_pkg::CRD_W'(1));
      m[psrg_pkg::POS_ZM]   = !lo[psrg_pkg::AX_Z];
      m[psrg_pkg::POS_YM]   = !lo[psrg_pkg::AX_Y];
      m[psrg_pkg::POS_XM]   = !lo[psrg_pkg::AX_X];
      m[psrg_pkg::POS_DIAG] = 1'b1;
      m[psrg_pkg::POS_ZP]   = !hi[psrg_pkg::AX_Z];
      m[psrg_pkg::POS_YP]   = !hi[psrg_pkg::AX_Y];
      m[psrg_pkg::POS_XP]   = !hi[psrg_pkg::AX_X];
    end
    cls_nxt.valid  = s.valid;
    cls_nxt.err    = err;
    cls_nxt.pinned = pin;
    cls_nxt.row    = err ? '0 : s.row;
    cls_nxt.mask   = (err || pin) ? psrg_pkg::MASK_DIAG : m;
    cls_nxt.lo     = lo;
    cls_nxt.hi     = hi;
    // A wall cell loses one neighbor along that axis, so its share is c, not 2c.
    cls_nxt.tx = (lo[psrg_pkg::AX_X] || hi[psrg_pkg::AX_X]) ?
                 psrg_pkg::TERM_W'(geom_i.cx) : {geom_i.cx, 1'b0};
    cls_nxt.ty = (lo[psrg_pkg::AX_Y] || hi[psrg_pkg::AX_Y]) ?
                 psrg_pkg::TERM_W'(geom_i.cy) : {geom_i.cy, 1'b0};
    cls_nxt.tz = (lo[psrg_pkg::AX_Z] || hi[psrg_pkg::AX_Z]) ?
                 psrg_pkg::TERM_W'(geom_i.cz) : {geom_i.cz, 1'b0};
  end

  // Diagonal value and the queue entry.
  always_comb begin
    logic [psrg_pkg::OUT_W-1:0] dzf;
    dzf = psrg_pkg::OUT_W'(0) - (psrg_pkg::OUT_W'(cls_r.tx) +
          psrg_pkg::OUT_W'(cls_r.ty) + psrg_pkg::OUT_W'(cls_r.tz));
    push_data_o.row  = cls_r.row;
    push_data_o.mask = cls_r.mask;
    push_data_o.lo   = cls_r.lo;
    push_data_o.hi   = cls_r.hi;
    push_data_o.err  = cls_r.err;
    if (cls_r.err) begin
      push_data_o.diag = '0;
    end else if (cls_r.pinned) begin
      push_data_o.diag = psrg_pkg::ONE_Q16;
    end else if (geom_i.periodic) begin
      push_data_o.diag = geom_i.diag_per;
    end else begin
      push_data_o.diag = dzf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= psrg_pkg::NDIV; k++) begin
        div_r[k].valid <= 1'b0;
      end
      cls_r.valid <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k <= psrg_pkg::NDIV; k++) begin
        div_r[k] <= div_nxt[k];
      end
      cls_r <= cls_nxt;
    end
  end

  `PSRG_ASSERT_NXT(a_front_holds, clk, rst_n, cls_r.valid && full_i, cls_r.valid)

endmodule

### rtl/psrg_fifo.sv
// Short queue of classified rows between the front end and the emitter.
// Depends on psrg_pkg.
`include "poisson_stencil_row_generator_core_defines.svh"

module psrg_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push_i,
  input  psrg_pkg::qent_t      push_data_i,
  input  logic                 pop_i,
  output psrg_pkg::qent_t      head_o,
  output psrg_pkg::fifo_stat_t stat_o
);

  psrg_pkg::qent_t                mem_r [psrg_pkg::FIFO_DEPTH];
  logic [psrg_pkg::FIFO_AW-1:0]   wr_ptr_r;
  logic [psrg_pkg::FIFO_AW-1:0]   wr_ptr_nxt;
  logic [psrg_pkg::FIFO_AW-1:0]   rd_ptr_r;
  logic [psrg_pkg::FIFO_AW-1:0]   rd_ptr_nxt;
  logic [psrg_pkg::FIFO_AW:0]     count_r;
  logic [psrg_pkg::FIFO_AW:0]     count_nxt;

  assign head_o       = mem_r[rd_ptr_r];
  assign stat_o.empty = count_r == '0;
  assign stat_o.full  = count_r == (psrg_pkg::FIFO_AW + 1)'(psrg_pkg::FIFO_DEPTH);

  always_comb begin
    wr_ptr_nxt = push_i ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_i ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= push_data_i;
    end
  end

  `PSRG_ASSERT_ALW(a_no_overflow, clk, rst_n, !(push_i && stat_o.full))
  `PSRG_ASSERT_ALW(a_no_underflow, clk, rst_n, !(pop_i && stat_o.empty))

endmodule

### rtl/psrg_back.sv
// Back end: walks the present entries of the queue head, one per unstalled cycle,
// forms column and coefficient, and drives the output register. Depends on psrg_pkg.
`include "poisson_stencil_row_generator_core_defines.svh"

module psrg_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  psrg_pkg::geom_t             geom_i,
  input  psrg_pkg::qent_t             head_i,
  input  psrg_pkg::fifo_stat_t        stat_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [psrg_pkg::ROW_W-1:0]  out_column_index_o,
  output logic signed [psrg_pkg::OUT_W-1:0] out_coefficient_o,
  output logic                        out_row_error_o,
  output logic                        out_last_entry_o
);

  logic                        busy_r;
  logic                        busy_nxt;
  logic [psrg_pkg::NPOS-1:0]   rem_r;
  logic [psrg_pkg::NPOS-1:0]   rem_nxt;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  logic [psrg_pkg::ROW_W-1:0]  out_col_r;
  logic [psrg_pkg::OUT_W-1:0]  out_coef_r;
  logic                        out_err_r;
  logic                        out_last_r;

  logic [psrg_pkg::NPOS-1:0]   cur;
  logic [psrg_pkg::NPOS-1:0]   oh;
  psrg_pkg::pos_t              pos;
  logic                        last;
  logic                        out_free;
  logic                        emit;
  logic                        add;
  logic [psrg_pkg::ROW_W-1:0]  mag;
  logic [psrg_pkg::ROW_W-1:0]  col;
  logic [psrg_pkg::OUT_W-1:0]  coef;

  assign out_free = !out_valid_r || !out_stall_i;
  assign emit     = !stat_i.empty && out_free;
  assign cur      = busy_r ? rem_r : head_i.mask;

  // Lowest remaining entry goes next.
  always_comb begin
    pos = psrg_pkg::POS_DIAG;
    for (int i = psrg_pkg::NPOS - 1; i >= 0; i--) begin
      if (cur[i]) begin
        pos = psrg_pkg::pos_t'(3'(i));
      end
    end
  end

  assign oh   = psrg_pkg::NPOS'(1) << pos;
  assign last = (cur & ~oh) == '0;

  // Neighbor column: one offset added to or taken from the row; a wrapped
  // neighbor on a periodic axis uses the span of the rest of that axis.
  always_comb begin
    add  = 1'b1;
    mag  = '0;
    coef = head_i.diag;
    case (pos)
      psrg_pkg::POS_ZM: begin
        add  = head_i.lo[psrg_pkg::AX_Z];
        mag  = add ? geom_i.off_zw : psrg_pkg::ROW_W'(geom_i.plane);
        coef = psrg_pkg::OUT_W'(geom_i.cz);
      end
      psrg_pkg::POS_YM: begin
        add  = head_i.lo[psrg_pkg::AX_Y];
        mag  = add ? geom_i.off_yw : psrg_pkg::ROW_W'(geom_i.nx);
        coef = psrg_pkg::OUT_W'(geom_i.cy);
      end
      psrg_pkg::POS_XM: begin
        add  = head_i.lo[psrg_pkg::AX_X];
        mag  = add ? geom_i.off_xw : psrg_pkg::ROW_W'(1);
        coef = psrg_pkg::OUT_W'(geom_i.cx);
      end
      psrg_pkg::POS_ZP: begin
        add  = !head_i.hi[psrg_pkg::AX_Z];
        mag  = add ? psrg_pkg::ROW_W'(geom_i.plane) : geom_i.off_zw;
        coef = psrg_pkg::OUT_W'(geom_i.cz);
      end
      psrg_pkg::POS_YP: begin
        add  = !head_i.hi[psrg_pkg::AX_Y];
        mag  = add ? psrg_pkg::ROW_W'(geom_i.nx) : geom_i.off_yw;
        coef = psrg_pkg::OUT_W'(geom_i.cy);
      end
      psrg_pkg::POS_XP: begin
        add  = !head_i.hi[psrg_pkg::AX_X];
        mag  = add ? psrg_pkg::ROW_W'(1) : geom_i.off_xw;
        coef = psrg_pkg::OUT_W'(geom_i.cx);
      end
      default: begin
        add  = 1'b1;
        mag  = '0;
        coef = head_i.diag;
      end
    endcase
    col = add ? head_i.row + mag : head_i.row - mag;
  end

  always_comb begin
    busy_nxt      = busy_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_free ? 1'b0 : out_valid_r;
    if (emit) begin
      busy_nxt      = !last;
      rem_nxt       = cur & ~oh;
      out_valid_nxt = 1'b1;
    end
  end

  assign pop_o = emit && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_col_r  <= col;
      out_coef_r <= coef;
      out_err_r  <= head_i.err;
      out_last_r <= last;
    end
  end

  assign out_valid_o        = out_valid_r;
  assign out_column_index_o = out_col_r;
  assign out_coefficient_o  = out_coef_r;
  assign out_row_error_o    = out_err_r;
  assign out_last_entry_o   = out_last_r;

  `PSRG_ASSERT_NXT(a_last_frees, clk, rst_n, emit && last, !busy_r)
  `PSRG_ASSERT_IMP(a_entry_present, clk, rst_n, emit, $onehot(oh) && ((cur & oh) != '0))

endmodule
